FILE: src/positional_queue_edit_defines.svh
// assertion macros for the positional queue edit block
`ifndef POSITIONAL_QUEUE_EDIT_DEFINES_SVH
`define POSITIONAL_QUEUE_EDIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define ASSERT_IMPL(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: src/pqe_pkg.sv
// shared types and constants for the positional queue edit block
`default_nettype none
package pqe_pkg;

  localparam int POS_W   = 5;
  localparam int COUNT_W = 5;
  localparam int VAL_W   = 32;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_SHR    = 2'd1,
    OP_SHL    = 2'd2,
    OP_DUMP   = 2'd3
  } pqe_op_t;

  typedef enum logic [1:0] {
    STAT_DONE   = 2'd0,
    STAT_REJECT = 2'd1,
    STAT_EMPTY  = 2'd2
  } pqe_status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_DUMP = 1'b1
  } pqe_state_t;

  typedef enum logic [1:0] {
    CM_HOLD   = 2'd0,
    CM_INSERT = 2'd1,
    CM_SHR    = 2'd2,
    CM_SHL    = 2'd3
  } cell_mode_t;

  typedef struct packed {
    cell_mode_t       mode;
    logic [POS_W-1:0] pos;
  } cell_ctrl_t;

endpackage
`default_nettype wire

FILE: src/pqe_cell.sv
// one list cell: holds an entry and takes it from a neighbor or the bus
`default_nettype none
module pqe_cell #(
  parameter int IDX   = 0,
  parameter int OCC_W = 5
) (
  input  wire                                 clk,
  input  wire pqe_pkg::cell_ctrl_t            ctrl,
  input  wire        [OCC_W-1:0]              occ,
  input  wire signed [pqe_pkg::VAL_W-1:0]     left_val,
  input  wire signed [pqe_pkg::VAL_W-1:0]     right_val,
  input  wire signed [pqe_pkg::VAL_W-1:0]     bus_val,
  output logic signed [pqe_pkg::VAL_W-1:0]    val
);

  localparam int CW = ((OCC_W > pqe_pkg::POS_W) ? OCC_W : pqe_pkg::POS_W) + 1;
  localparam logic [CW-1:0] IDX_C = CW'(IDX);

  logic        [CW-1:0]            pos_c;
  logic        [CW-1:0]            occ_c;
  logic        [CW-1:0]            occ_m1;
  logic signed [pqe_pkg::VAL_W-1:0] val_next;

  assign pos_c  = CW'(ctrl.pos);
  assign occ_c  = CW'(occ);
  assign occ_m1 = occ_c - CW'(1);

  always_comb begin
    val_next = val;
    case (ctrl.mode)
      pqe_pkg::CM_INSERT: begin
        if (IDX_C == pos_c) val_next = bus_val;
        else if (IDX_C > pos_c && IDX_C <= occ_c) val_next = left_val;
      end
      pqe_pkg::CM_SHR: begin
        if (IDX_C == pos_c) val_next = bus_val;
        else if (IDX_C > pos_c && IDX_C <= occ_m1) val_next = left_val;
      end
      pqe_pkg::CM_SHL: begin
        // tail cell receives the picked entry, the span before it moves down
        if (IDX_C == occ_m1) val_next = bus_val;
        else if (IDX_C >= pos_c && IDX_C < occ_m1) val_next = right_val;
      end
      default: val_next = val;
    endcase
  end

  always_ff @(posedge clk) begin
    val <= val_next;
  end

endmodule
`default_nettype wire

FILE: src/positional_queue_edit.sv
// top level: a row of list cells with edit control and dump sequencer
//
// Ordered list of up to CAPACITY signed 32-bit entries, held in a row of
// cells that all move in the same cycle.
// Input: a transaction is taken on a rising edge with start high and busy
// low; operation, value and position are sampled at that edge.
// Output: each result is shown for one cycle with result_strobe high and
// must be taken then; the receiver cannot stall the block.
// Insert, shift right and shift left: the result comes in the cycle after
// the transaction, busy stays low and a new transaction can follow in the
// next cycle.
// Dump of n entries: busy goes high, the cells rotate once per cycle and the
// head entry goes out each cycle, so n results follow back to back, the
// last one marked by last; the next transaction is taken once busy is low
// again. An empty list gives one empty result in the cycle after the
// transaction. The dump rate is set by the single head tap of the cell row.
// Reset clears the occupancy and the sequencer; entry contents are left
// as they are and are never read before being written.
`default_nettype none
`include "positional_queue_edit_defines.svh"
module positional_queue_edit #(
  parameter int CAPACITY = 16
) (
  input  wire                                    clk,
  input  wire                                    rst,
  input  wire                                    start,
  output logic                                   busy,
  input  wire        [1:0]                       operation,
  input  wire signed [pqe_pkg::VAL_W-1:0]        value,
  input  wire        [pqe_pkg::POS_W-1:0]        position,
  output logic                                   result_strobe,
  output logic       [1:0]                       status,
  output logic       [pqe_pkg::COUNT_W-1:0]      count,
  output logic signed [pqe_pkg::VAL_W-1:0]       entry_value,
  output logic                                   last
);

  localparam int OCC_W = $clog2(CAPACITY + 1);
  localparam int AW    = $clog2(CAPACITY);
  localparam int CW    = ((OCC_W > pqe_pkg::POS_W) ? OCC_W : pqe_pkg::POS_W) + 1;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  pqe_pkg::pqe_state_t state, state_next;
  pqe_pkg::pqe_op_t    op;
  pqe_pkg::cell_ctrl_t ctrl;

  logic        [OCC_W-1:0]           occ, occ_next;
  logic        [AW-1:0]              dump_idx;
  logic        [AW-1:0]              pick_addr;
  logic        [CW-1:0]              pos_c, occ_c, occ_m1;
  logic                              accept, ins_ok, shr_ok, shl_ok, edit_ok, dump_last;
  logic signed [pqe_pkg::VAL_W-1:0]  vals [CAPACITY];
  logic signed [pqe_pkg::VAL_W-1:0]  picked, bus_val;

  assign op     = pqe_pkg::pqe_op_t'(operation);
  assign busy   = (state == pqe_pkg::S_DUMP);
  assign accept = start && !busy;

  assign pos_c  = CW'(position);
  assign occ_c  = CW'(occ);
  assign occ_m1 = occ_c - CW'(1);
  assign ins_ok = (pos_c <= occ_c) && (occ_c < CAP_C);
  assign shr_ok = (pos_c + CW'(1)) < occ_c;
  assign shl_ok = pos_c < occ_c;
  assign dump_last = (CW'(dump_idx) == occ_m1);

  assign picked  = vals[pick_addr];
  assign bus_val = (ctrl.mode == pqe_pkg::CM_INSERT) ? value : picked;

  // cell row
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [pqe_pkg::VAL_W-1:0] left_in, right_in;
    if (i == 0) begin : g_head
      assign left_in = bus_val;
    end else begin : g_mid_l
      assign left_in = vals[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign right_in = bus_val;
    end else begin : g_mid_r
      assign right_in = vals[i+1];
    end
    pqe_cell #(.IDX(i), .OCC_W(OCC_W)) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .occ       (occ),
      .left_val  (left_in),
      .right_val (right_in),
      .bus_val   (bus_val),
      .val       (vals[i])
    );
  end

  always_comb begin
    state_next = state;
    ctrl.mode  = pqe_pkg::CM_HOLD;
    ctrl.pos   = position;
    pick_addr  = '0;
    occ_next   = occ;
    edit_ok    = 1'b0;
    case (state)
      pqe_pkg::S_IDLE: begin
        if (start) begin
          case (op)
            pqe_pkg::OP_INSERT: begin
              edit_ok = ins_ok;
              if (ins_ok) begin
                ctrl.mode = pqe_pkg::CM_INSERT;
                occ_next  = occ + OCC_W'(1);
              end
            end
            pqe_pkg::OP_SHR: begin
              edit_ok   = shr_ok;
              pick_addr = occ_m1[AW-1:0];
              if (shr_ok) ctrl.mode = pqe_pkg::CM_SHR;
            end
            pqe_pkg::OP_SHL: begin
              edit_ok   = shl_ok;
              pick_addr = pos_c[AW-1:0];
              if (shl_ok) ctrl.mode = pqe_pkg::CM_SHL;
            end
            pqe_pkg::OP_DUMP: begin
              if (occ != '0) state_next = pqe_pkg::S_DUMP;
            end
            default: state_next = state;
          endcase
        end
      end
      pqe_pkg::S_DUMP: begin
        // rotate by one: head goes out and wraps to the tail
        ctrl.mode = pqe_pkg::CM_SHL;
        ctrl.pos  = '0;
        if (dump_last) state_next = pqe_pkg::S_IDLE;
      end
      default: state_next = pqe_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= pqe_pkg::S_IDLE;
      occ           <= '0;
      dump_idx      <= '0;
      result_strobe <= 1'b0;
    end else begin
      state         <= state_next;
      occ           <= occ_next;
      result_strobe <= 1'b0;
      if (state == pqe_pkg::S_DUMP) begin
        dump_idx      <= dump_idx + AW'(1);
        result_strobe <= 1'b1;
      end else if (accept) begin
        dump_idx      <= '0;
        // a dump of a filled list reports only from the sequencer
        result_strobe <= !(op == pqe_pkg::OP_DUMP && occ != '0);
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (state == pqe_pkg::S_DUMP) begin
      status      <= pqe_pkg::STAT_DONE;
      count       <= pqe_pkg::COUNT_W'(occ);
      entry_value <= vals[0];
      last        <= dump_last;
    end else if (accept) begin
      entry_value <= '0;
      last        <= 1'b1;
      count       <= pqe_pkg::COUNT_W'(occ_next);
      if (op == pqe_pkg::OP_DUMP) status <= pqe_pkg::STAT_EMPTY;
      else if (edit_ok) status <= pqe_pkg::STAT_DONE;
      else status <= pqe_pkg::STAT_REJECT;
    end
  end

  `ASSERT_IMPL(a_occ_cap, clk, rst, 1'b1, occ_c <= CAP_C)
  `ASSERT_NEXT(a_edit_one_result, clk, rst, accept && op != pqe_pkg::OP_DUMP, result_strobe && last)
  `ASSERT_NEXT(a_dump_occ_stable, clk, rst, state == pqe_pkg::S_DUMP, $stable(occ))
  `ASSERT_NEXT(a_dump_contiguous, clk, rst, result_strobe && !last, result_strobe)
  `ASSERT_IMPL(a_empty_count, clk, rst, result_strobe && status == pqe_pkg::STAT_EMPTY, count == '0)

endmodule
`default_nettype wire
